/* rtl/core/cps_pkg.sv */
// Shared types and constants of the closest point search block.
package cps_pkg;

    localparam int FIELD_W     = 16;
    localparam int INDEX_W     = 16;
    localparam int DIST_W      = 35;
    localparam int SQ_W        = 34;
    localparam int ROOT_OUT_W  = 17;
    localparam int ROOT_W      = (DIST_W + 1) / 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 2;

    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_QUERY_X = 2'd0,
        REG_QUERY_Y = 2'd1,
        REG_QUERY_Z = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ROOT_IDLE,
        ROOT_RUN,
        ROOT_HOLD
    } root_state_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [DIST_W-1:0]  sq_dist;
    } scan_result_t;

    typedef struct packed {
        logic         valid;
        scan_result_t data;
    } scan_req_t;

endpackage

/* rtl/core/cps_point_if.sv */
// Point channel: one request carries one point of a scan.
interface cps_point_if;
    logic                              valid;
    logic                              ready;
    logic signed [cps_pkg::FIELD_W-1:0] vertex_x;
    logic signed [cps_pkg::FIELD_W-1:0] vertex_y;
    logic signed [cps_pkg::FIELD_W-1:0] vertex_z;
    logic                              last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, vertex_z, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, vertex_x, vertex_y, vertex_z, last_vertex,
        output ready
    );
endinterface

/* rtl/core/cps_result_if.sv */
// Result channel: one request carries the closest point of a finished scan.
interface cps_result_if;
    logic                               valid;
    logic                               ready;
    logic [cps_pkg::INDEX_W-1:0]        best_index;
    logic [cps_pkg::SQ_W-1:0]           distance_squared;
    logic [cps_pkg::ROOT_OUT_W-1:0]     distance;

    modport source (
        output valid, best_index, distance_squared, distance,
        input  ready
    );

    modport sink (
        input  valid, best_index, distance_squared, distance,
        output ready
    );
endinterface

/* rtl/core/closest_point_search.sv */
// Top level of the closest point search block.
//
// Points arrive on the vertex channel, one request per point, valid/ready
// handshake. Each point is compared by squared distance against the query
// point held in three configuration registers (index 0 x, 1 y, 2 z),
// written through cfg_we/cfg_index/cfg_data while no scan is in flight.
// A point with last_vertex set closes the scan; one request then leaves on
// the result channel with the position of the closest point (first one on
// a tie), its squared distance and the floor square root of it.
// Throughput: one point per cycle while a queue slot is free. The result
// of a scan passes the distance pipeline, the queue, the square root
// sequencer (one result bit per cycle) and the output register. Up to
// two finished scans wait in the queue while the root unit works; a
// third scan's points stall until one leaves. A stalled result holds in
// the output register while the next scan keeps streaming in.
// Reset clears the query to zero, the scan state and all pending requests.
module closest_point_search #(
    parameter int MAX_VERTICES = 65536,
    parameter int COORD_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cps_point_if.sink                         vertex,
    cps_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [cps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cps_pkg::FIELD_W-1:0]       cfg_data
);

    logic [cps_pkg::FIELD_W-1:0] query_x_reg, query_x_next;
    logic [cps_pkg::FIELD_W-1:0] query_y_reg, query_y_next;
    logic [cps_pkg::FIELD_W-1:0] query_z_reg, query_z_next;

    cps_pkg::scan_req_t push;
    cps_pkg::scan_req_t head;
    logic               queue_full;
    logic               pop;

    always_comb
    begin
        query_x_next = query_x_reg;
        query_y_next = query_y_reg;
        query_z_next = query_z_reg;
        if (cfg_we)
        begin
            unique case (cps_pkg::cfg_reg_t'(cfg_index))
                cps_pkg::REG_QUERY_X: query_x_next = cfg_data;
                cps_pkg::REG_QUERY_Y: query_y_next = cfg_data;
                cps_pkg::REG_QUERY_Z: query_z_next = cfg_data;
                default:
                begin
                    query_x_next = query_x_reg;
                    query_y_next = query_y_reg;
                    query_z_next = query_z_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg <= '0;
            query_y_reg <= '0;
            query_z_reg <= '0;
        end
        else
        begin
            query_x_reg <= query_x_next;
            query_y_reg <= query_y_next;
            query_z_reg <= query_z_next;
        end
    end

    cps_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertex    (vertex),
        .query_x   (query_x_reg),
        .query_y   (query_y_reg),
        .query_z   (query_z_reg),
        .slot_free (pop),
        .push      (push)
    );

    cps_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (queue_full)
    );

    cps_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

    a_no_push_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        push.valid |-> !queue_full
    ) else $error("scan minimum pushed into a full queue");

    a_pop_needs_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        pop |-> head.valid
    ) else $error("root unit took an entry from an empty queue");

    a_pop_starts_root: assert property (
        @(posedge clk) disable iff (!rst_n)
        pop |=> !pop
    ) else $error("root unit took two entries in consecutive cycles");

endmodule

/* rtl/core/cps_front.sv */
// Front end: distance pipeline, running minimum, scan position counter and queue credits.
module cps_front #(
    parameter int MAX_VERTICES = 65536,
    parameter int COORD_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cps_point_if.sink                       vertex,
    input  logic [cps_pkg::FIELD_W-1:0]     query_x,
    input  logic [cps_pkg::FIELD_W-1:0]     query_y,
    input  logic [cps_pkg::FIELD_W-1:0]     query_z,
    input  logic                            slot_free,
    output cps_pkg::scan_req_t              push
);

    localparam int CW       = COORD_BITS;
    localparam int SQ_BITS  = 2 * CW;
    localparam int SUM_BITS = 2 * CW + 2;
    localparam int IDX_MAX  = (1 << cps_pkg::INDEX_W) - 1;
    localparam int LIMIT    = (MAX_VERTICES - 1 > IDX_MAX) ? IDX_MAX : MAX_VERTICES - 1;
    localparam int CNT_W    = $clog2(LIMIT + 1);
    localparam int CREDIT_W = $clog2(cps_pkg::QUEUE_DEPTH + 1);

    function automatic logic [CW-1:0] axis_mag(
        input logic [cps_pkg::FIELD_W-1:0] a,
        input logic [cps_pkg::FIELD_W-1:0] b
    );
        logic [CW-1:0]     ca;
        logic [CW-1:0]     cb;
        logic signed [CW:0] d;
        ca = CW'(a);
        cb = CW'(b);
        d  = $signed({ca[CW-1], ca}) - $signed({cb[CW-1], cb});
        return d[CW] ? CW'(-d) : d[CW-1:0];
    endfunction

    logic                  accept;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CREDIT_W-1:0]   credit_reg, credit_next;

    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                  s1_last_reg, s2_last_reg, s3_last_reg;
    logic [CNT_W-1:0]      s1_pos_reg, s2_pos_reg, s3_pos_reg;
    logic [CW-1:0]         s1_mag_reg [3];
    logic [SQ_BITS-1:0]    s2_sq_reg [3];
    logic [cps_pkg::DIST_W-1:0] s3_dist_reg;

    logic [cps_pkg::DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [CNT_W-1:0]      best_pos_reg, best_pos_next;
    logic                  closer;
    logic [cps_pkg::DIST_W-1:0] cand_dist;
    logic [CNT_W-1:0]      cand_pos;
    logic [SUM_BITS-1:0]   sum;

    assign vertex.ready = (credit_reg != '0);
    assign accept       = vertex.valid && vertex.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (vertex.last_vertex)
                cnt_next = '0;
            else if (cnt_reg < CNT_W'(LIMIT))
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        credit_next = credit_reg;
        case ({accept && vertex.last_vertex, slot_free})
            2'b10:   credit_next = credit_reg - 1'b1;
            2'b01:   credit_next = credit_reg + 1'b1;
            default: credit_next = credit_reg;
        endcase
    end

    assign sum = SUM_BITS'(s2_sq_reg[0]) + SUM_BITS'(s2_sq_reg[1]) + SUM_BITS'(s2_sq_reg[2]);

    assign closer    = s3_dist_reg < best_dist_reg;
    assign cand_dist = closer ? s3_dist_reg : best_dist_reg;
    assign cand_pos  = closer ? s3_pos_reg : best_pos_reg;

    always_comb
    begin
        best_dist_next = best_dist_reg;
        best_pos_next  = best_pos_reg;
        if (s3_valid_reg)
        begin
            if (s3_last_reg)
            begin
                best_dist_next = cps_pkg::DIST_NONE;
                best_pos_next  = '0;
            end
            else
            begin
                best_dist_next = cand_dist;
                best_pos_next  = cand_pos;
            end
        end
    end

    assign push.valid        = s3_valid_reg && s3_last_reg;
    assign push.data.index   = cps_pkg::INDEX_W'(cand_pos);
    assign push.data.sq_dist = cand_dist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            credit_reg    <= CREDIT_W'(cps_pkg::QUEUE_DEPTH);
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            best_dist_reg <= cps_pkg::DIST_NONE;
            best_pos_reg  <= '0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            credit_reg    <= credit_next;
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            best_dist_reg <= best_dist_next;
            best_pos_reg  <= best_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg   <= vertex.last_vertex;
        s1_pos_reg    <= cnt_reg;
        s1_mag_reg[0] <= axis_mag(vertex.vertex_x, query_x);
        s1_mag_reg[1] <= axis_mag(vertex.vertex_y, query_y);
        s1_mag_reg[2] <= axis_mag(vertex.vertex_z, query_z);
        s2_last_reg   <= s1_last_reg;
        s2_pos_reg    <= s1_pos_reg;
        s2_sq_reg[0]  <= s1_mag_reg[0] * s1_mag_reg[0];
        s2_sq_reg[1]  <= s1_mag_reg[1] * s1_mag_reg[1];
        s2_sq_reg[2]  <= s1_mag_reg[2] * s1_mag_reg[2];
        s3_last_reg   <= s2_last_reg;
        s3_pos_reg    <= s2_pos_reg;
        s3_dist_reg   <= cps_pkg::DIST_W'(sum);
    end

endmodule

/* rtl/core/cps_queue.sv */
// Short queue of finished scan minima between front and back end.
module cps_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cps_pkg::scan_req_t   push,
    input  logic                 pop,
    output cps_pkg::scan_req_t   head,
    output logic                 full
);

    localparam int PTR_W = $clog2(cps_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cps_pkg::QUEUE_DEPTH + 1);

    cps_pkg::scan_result_t entry_reg [cps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head.valid = (count_reg != '0);
    assign head.data  = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == CNT_W'(cps_pkg::QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push.valid ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        case ({push.valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.data;
    end

endmodule

/* rtl/core/cps_back.sv */
// Back end: bit-pair square root sequencer and result output register.
module cps_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cps_pkg::scan_req_t   head,
    output logic                 pop,
    cps_result_if.source         result
);

    localparam int RW     = cps_pkg::ROOT_W;
    localparam int STEP_W = $clog2(RW);

    cps_pkg::root_state_t state_reg, state_next;

    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       last_step;
    logic                       out_free;
    logic                       load_out;

    logic [cps_pkg::INDEX_W-1:0] idx_reg;
    logic [cps_pkg::DIST_W-1:0]  dist_reg;
    logic [2*RW-1:0]             val_reg;
    logic [RW:0]                 rem_reg, rem_next;
    logic [RW-1:0]               root_reg, root_next;
    logic [RW+1:0]               cur;
    logic [RW+1:0]               trial;

    logic                        out_valid_reg, out_valid_next;
    logic [cps_pkg::INDEX_W-1:0]    out_index_reg;
    logic [cps_pkg::SQ_W-1:0]       out_sq_reg;
    logic [cps_pkg::ROOT_OUT_W-1:0] out_root_reg;

    assign last_step = (step_reg == STEP_W'(RW - 1));
    assign out_free  = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cps_pkg::ROOT_IDLE:
                if (head.valid)
                    state_next = cps_pkg::ROOT_RUN;
            cps_pkg::ROOT_RUN:
                if (last_step)
                    state_next = cps_pkg::ROOT_HOLD;
            cps_pkg::ROOT_HOLD:
                if (out_free)
                    state_next = cps_pkg::ROOT_IDLE;
            default:
                state_next = cps_pkg::ROOT_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            cps_pkg::ROOT_IDLE: pop      = head.valid;
            cps_pkg::ROOT_RUN:  pop      = 1'b0;
            cps_pkg::ROOT_HOLD: load_out = out_free;
            default:
            begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // one result bit per step: bring down two bits, try to subtract 4*root+1
    assign cur   = {rem_reg[RW-1:0], val_reg[2*RW-1 -: 2]};
    assign trial = {root_reg, 2'b01};

    always_comb
    begin
        if (cur >= trial)
        begin
            rem_next  = (RW+1)'(cur - trial);
            root_next = {root_reg[RW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = cur[RW:0];
            root_next = {root_reg[RW-2:0], 1'b0};
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (pop)
            step_next = '0;
        else if (state_reg == cps_pkg::ROOT_RUN)
            step_next = step_reg + 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cps_pkg::ROOT_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            idx_reg  <= head.data.index;
            dist_reg <= head.data.sq_dist;
            val_reg  <= (2*RW)'(head.data.sq_dist);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (state_reg == cps_pkg::ROOT_RUN)
        begin
            val_reg  <= {val_reg[2*RW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (load_out)
        begin
            out_index_reg <= idx_reg;
            out_sq_reg    <= dist_reg[cps_pkg::SQ_W-1:0];
            out_root_reg  <= root_reg[cps_pkg::ROOT_OUT_W-1:0];
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.best_index       = out_index_reg;
    assign result.distance_squared = out_sq_reg;
    assign result.distance         = out_root_reg;

endmodule

/* test/tb_top.sv */
// Testbench of the closest point search block: random and directed scans against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 32;
    localparam int CNT_LIMIT    = 65535;
    localparam int PHASE_POINTS = 140;
    localparam int RANDOM_PHASES = 11;

    localparam logic [cps_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam logic signed [cps_pkg::FIELD_W-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [cps_pkg::FIELD_W-1:0] COORD_MAX = 16'sh7fff;

    typedef struct packed {
        logic signed [cps_pkg::FIELD_W-1:0] x;
        logic signed [cps_pkg::FIELD_W-1:0] y;
        logic signed [cps_pkg::FIELD_W-1:0] z;
        logic                               last;
    } point_t;

    typedef struct packed {
        logic [cps_pkg::INDEX_W-1:0]    index;
        logic [cps_pkg::SQ_W-1:0]       sq;
        logic [cps_pkg::ROOT_OUT_W-1:0] root;
    } scan_outcome_t;

    logic clk;
    logic rst_n;
    logic                             cfg_we;
    logic [cps_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [cps_pkg::FIELD_W-1:0]      cfg_data;

    cps_point_if  vertex_ch ();
    cps_result_if result_ch ();

    closest_point_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertex    (vertex_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    point_t        pending_points[$];
    scan_outcome_t expected_outcomes[$];
    point_t        point_on_bus;
    point_t        prev_point;

    logic signed [cps_pkg::FIELD_W-1:0] query_x;
    logic signed [cps_pkg::FIELD_W-1:0] query_y;
    logic signed [cps_pkg::FIELD_W-1:0] query_z;
    logic [cps_pkg::DIST_W-1:0]         best_dist;
    logic [cps_pkg::INDEX_W-1:0]        best_pos;
    logic [cps_pkg::INDEX_W-1:0]        point_cnt;

    int errors;
    int cycles;
    int gap_left;
    int stall_left;
    bit calm;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [cps_pkg::DIST_W-1:0] span_squared(input point_t p);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(p.x)) - longint'(query_x);
        dy = longint'($signed(p.y)) - longint'(query_y);
        dz = longint'($signed(p.z)) - longint'(query_z);
        return cps_pkg::DIST_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic logic [cps_pkg::ROOT_OUT_W-1:0] floor_root(
            input logic [cps_pkg::DIST_W-1:0] v);
        longint unsigned res;
        longint unsigned trial;
        res = 0;
        for (int b = 18; b >= 0; b--)
        begin
            trial = res | (longint'(1) << b);
            if (trial * trial <= v)
                res = trial;
        end
        return cps_pkg::ROOT_OUT_W'(res);
    endfunction

    task automatic clear_scan();
        best_dist = cps_pkg::DIST_NONE;
        best_pos  = '0;
        point_cnt = '0;
    endtask

    task automatic predict_point(input point_t p);
        logic [cps_pkg::DIST_W-1:0] d2;
        scan_outcome_t              o;
        d2 = span_squared(p);
        if (d2 < best_dist)
        begin
            best_dist = d2;
            best_pos  = point_cnt;
        end
        if (point_cnt < CNT_LIMIT)
            point_cnt++;
        if (p.last)
        begin
            o.index = best_pos;
            o.sq    = best_dist[cps_pkg::SQ_W-1:0];
            o.root  = floor_root(best_dist);
            expected_outcomes.insert(expected_outcomes.size(), o);
            clear_scan();
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive point requests
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            vertex_ch.valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (vertex_ch.valid && vertex_ch.ready)
                predict_point(point_on_bus);
            if (!vertex_ch.valid || vertex_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    vertex_ch.valid <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    point_on_bus = pending_points.pop_front();
                    vertex_ch.vertex_x    <= point_on_bus.x;
                    vertex_ch.vertex_y    <= point_on_bus.y;
                    vertex_ch.vertex_z    <= point_on_bus.z;
                    vertex_ch.last_vertex <= point_on_bus.last;
                    vertex_ch.valid       <= 1'b1;
                    gap_left <= pick_gap();
                end
                else
                    vertex_ch.valid <= 1'b0;
            end
        end
    end

    // stall the result channel
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (calm)
        begin
            result_ch.ready <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 80)
            result_ch.ready <= 1'b1;
        else
        begin
            result_ch.ready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(10, 40);
        end
    end

    always @(posedge clk)
    begin
        scan_outcome_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t unexpected result: index %0d sq %0d root %0d", $time,
                         result_ch.best_index, result_ch.distance_squared,
                         result_ch.distance);
                errors++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (result_ch.best_index !== want.index)
                begin
                    $display("%0t best_index: expected %0d actual %0d", $time,
                             want.index, result_ch.best_index);
                    errors++;
                end
                if (result_ch.distance_squared !== want.sq)
                begin
                    $display("%0t distance_squared: expected %0d actual %0d", $time,
                             want.sq, result_ch.distance_squared);
                    errors++;
                end
                if (result_ch.distance !== want.root)
                begin
                    $display("%0t distance: expected %0d actual %0d", $time,
                             want.root, result_ch.distance);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [cps_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [cps_pkg::FIELD_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            cps_pkg::REG_QUERY_X: query_x = val;
            cps_pkg::REG_QUERY_Y: query_y = val;
            cps_pkg::REG_QUERY_Z: query_z = val;
            default: ;
        endcase
    endtask

    task automatic set_query(input logic [cps_pkg::FIELD_W-1:0] qx,
                             input logic [cps_pkg::FIELD_W-1:0] qy,
                             input logic [cps_pkg::FIELD_W-1:0] qz);
        write_reg(cps_pkg::REG_QUERY_X, qx);
        write_reg(cps_pkg::REG_QUERY_Y, qy);
        write_reg(cps_pkg::REG_QUERY_Z, qz);
    endtask

    task automatic queue_point(input logic signed [cps_pkg::FIELD_W-1:0] x,
                               input logic signed [cps_pkg::FIELD_W-1:0] y,
                               input logic signed [cps_pkg::FIELD_W-1:0] z, input logic last);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.last = last;
        pending_points.insert(pending_points.size(), p);
        prev_point = p;
    endtask

    // hold until every request has gone and every result has come
    task automatic drain();
        while (pending_points.size() != 0 || vertex_ch.valid || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [cps_pkg::FIELD_W-1:0] pick_coord(
            input logic signed [cps_pkg::FIELD_W-1:0] q, input int kind);
        logic [cps_pkg::FIELD_W-1:0] off;
        case (kind)
            0: return cps_pkg::FIELD_W'($urandom);
            1:
            begin
                off = cps_pkg::FIELD_W'($urandom_range(0, 16));
                return q + off - 16'd8;
            end
            default:
                case ($urandom_range(0, 3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    default: return '1;
                endcase
        endcase
    endfunction

    function automatic logic [cps_pkg::FIELD_W-1:0] pick_query(input int ph);
        case (ph)
            1: return COORD_MAX;
            2: return COORD_MIN;
            5: return '0;
            default: return pick_coord('0, ($urandom_range(0, 3) == 0) ? 2 : 0);
        endcase
    endfunction

    task automatic add_random_scan(input int n);
        int  r;
        int  kind;
        logic last;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            kind = (r < 40) ? 0 : (r < 75) ? 1 : 2;
            last = (i == n - 1);
            if (r >= 88 && i > 0)
                queue_point(prev_point.x, prev_point.y, prev_point.z, last);
            else
                queue_point(pick_coord(query_x, kind), pick_coord(query_y, kind),
                            pick_coord(query_z, kind), last);
        end
    endtask

    initial
    begin
        int issued;
        int n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        vertex_ch.valid = 1'b0;
        vertex_ch.vertex_x = '0;
        vertex_ch.vertex_y = '0;
        vertex_ch.vertex_z = '0;
        vertex_ch.last_vertex = 1'b0;
        result_ch.ready = 1'b0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        query_x = '0;
        query_y = '0;
        query_z = '0;
        clear_scan();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // single point, extremes, ties, late winner
        queue_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        queue_point(16'sd3, 16'sd4, 16'sd0, 1'b0);
        queue_point(16'sd0, 16'sd3, 16'sd4, 1'b0);
        queue_point(16'sd4, 16'sd0, 16'sd3, 1'b1);
        queue_point(16'sd100, 16'sd0, 16'sd0, 1'b0);
        queue_point(16'sd50, 16'sd0, 16'sd0, 1'b0);
        queue_point(16'sd50, 16'sd0, 16'sd0, 1'b0);
        queue_point(16'sd10, -16'sd10, 16'sd0, 1'b1);
        drain();

        set_query(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        drain();

        set_query(COORD_MIN, COORD_MIN, COORD_MIN);
        write_reg(REG_SPARE, 16'h1234);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN + 16'sd1, 1'b1);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            calm = (ph % 4 == 3);
            set_query(pick_query(ph), pick_query(ph), pick_query(ph));
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_SPARE, cps_pkg::FIELD_W'($urandom));
            issued = 0;
            while (issued < PHASE_POINTS)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                : $urandom_range(1, 12);
                add_random_scan(n);
                issued += n;
            end
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
